@@ rtl/tlbsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbsc_pkg
// Shared constants and types for the page translation block with a
// second-chance TLB.
// ----------------------------------------------------------------------------
package tlbsc_pkg;

    localparam int ADDR_W      = 20;
    localparam int OFFSET_WIDTH = 10;
    localparam int PAGE_COUNT  = 1024;
    localparam int TLB_ENTRIES = 16;

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = PAGE_W;
    localparam int NFF_W   = PAGE_W + 1;
    localparam int HAND_W  = $clog2(TLB_ENTRIES);

    // commands from the sequencer to the tlb
    typedef struct packed {
        logic touch;   // set the reference bit of the matching entry
        logic step;    // one step of the clock hand: clear and pass, or insert here
    } tlb_cmd_t;

    // tlb status back to the sequencer
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               hand_ref;
    } tlb_stat_t;

    // one page table word
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } ptab_word_t;

endpackage

@@ rtl/tlbsc_tlb.sv @@
// ----------------------------------------------------------------------------
// tlbsc_tlb
// Fully associative TLB with reference bits and a clock hand for
// second-chance replacement.
// ----------------------------------------------------------------------------
module tlbsc_tlb
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tlbsc_pkg::PAGE_W-1:0]  page,
    input  logic [tlbsc_pkg::FRAME_W-1:0] frame,
    input  tlbsc_pkg::tlb_cmd_t        cmd,
    output tlbsc_pkg::tlb_stat_t       stat
);
    import tlbsc_pkg::*;

    logic [PAGE_W-1:0]      tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_ENTRIES-1:0] valid_next;
    logic [TLB_ENTRIES-1:0] ref_reg;
    logic [TLB_ENTRIES-1:0] ref_next;
    logic [HAND_W-1:0]      hand_reg;
    logic [HAND_W-1:0]      hand_next;
    logic [HAND_W-1:0]      hand_inc;
    logic [TLB_ENTRIES-1:0] match_vec;
    logic [HAND_W-1:0]      hit_idx;
    logic                   hit;
    logic                   insert;

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (tag_reg[i] == page);
        end
    end

    // lowest matching index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = HAND_W'(i);
            end
        end
    end

    assign stat.hit      = hit;
    assign stat.frame    = frame_reg[hit_idx];
    assign stat.hand_ref = ref_reg[hand_reg];

    assign hand_inc = (hand_reg == HAND_W'(TLB_ENTRIES - 1)) ? '0 : hand_reg + 1'b1;
    assign insert   = cmd.step && !ref_reg[hand_reg];

    always_comb
    begin
        ref_next   = ref_reg;
        valid_next = valid_reg;
        hand_next  = hand_reg;
        if (cmd.touch && hit)
        begin
            ref_next[hit_idx] = 1'b1;
        end
        if (cmd.step)
        begin
            ref_next[hand_reg] = 1'b0;
            hand_next          = hand_inc;
            if (insert)
            begin
                valid_next[hand_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg   <= '0;
            valid_reg <= '0;
            hand_reg  <= '0;
        end
        else
        begin
            ref_reg   <= ref_next;
            valid_reg <= valid_next;
            hand_reg  <= hand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            tag_reg[hand_reg]   <= page;
            frame_reg[hand_reg] <= frame;
        end
    end

endmodule

@@ rtl/tlbsc_ptab.sv @@
// ----------------------------------------------------------------------------
// tlbsc_ptab
// Page table memory, one word per page, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module tlbsc_ptab
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [tlbsc_pkg::PAGE_W-1:0]  rd_page,
    output tlbsc_pkg::ptab_word_t         rd_word,
    input  logic                          wr_en,
    input  logic [tlbsc_pkg::PAGE_W-1:0]  wr_page,
    input  tlbsc_pkg::ptab_word_t         wr_word,
    output logic                          clearing
);
    import tlbsc_pkg::*;

    ptab_word_t        mem [PAGE_COUNT];
    ptab_word_t        rd_word_reg;
    logic [PAGE_W-1:0] clr_idx_reg;
    logic [PAGE_W-1:0] clr_idx_next;
    logic              clr_active_reg;
    logic              clr_active_next;

    always_comb
    begin
        clr_idx_next    = clr_idx_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == PAGE_W'(PAGE_COUNT - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            clr_active_reg <= 1'b1;
        end
        else
        begin
            clr_idx_reg    <= clr_idx_next;
            clr_active_reg <= clr_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_page] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_page];
        end
    end

    assign rd_word  = rd_word_reg;
    assign clearing = clr_active_reg;

endmodule

@@ rtl/tlb_page_translation_second_chance_top.sv @@
// ----------------------------------------------------------------------------
// tlb_page_translation_second_chance_top
// A TLB hit raises done from the lookup state; a miss goes on to the sweep,
// where the clock hand passes the referenced entries, up to every entry in the TLB.
// A new word is taken in the same cycle done is high; the receiver cannot
// stall, and done is high for one cycle only per result.
// After reset the page table is cleared with busy high.
// ----------------------------------------------------------------------------
module tlb_page_translation_second_chance_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tlbsc_pkg::ADDR_W-1:0]  vaddr,
    output logic                          busy,
    output logic                          done,
    output logic [tlbsc_pkg::ADDR_W-1:0]  paddr,
    output logic                          tlb_hit,
    output logic                          page_fault
);
    import tlbsc_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_SWEEP  = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic               fault_reg;
    logic               fault_next;
    logic [NFF_W-1:0]   nff_reg;
    logic [NFF_W-1:0]   nff_next;
    logic [ADDR_W-1:0]  pa_reg;
    logic [ADDR_W-1:0]  pa_next;
    logic               hit_reg;
    logic               hit_next;
    logic               pf_reg;
    logic               pf_next;
    logic               done_reg;
    logic               done_next;

    logic               accept;
    logic               clearing;
    logic [PAGE_W-1:0]  in_page;
    logic [PAGE_W-1:0]  cur_page;
    logic [OFFSET_WIDTH-1:0] cur_offset;
    tlb_cmd_t           tcmd;
    tlb_stat_t          tstat;
    ptab_word_t         pt_rd;
    ptab_word_t         pt_wr;
    logic               pt_wr_en;

    assign busy       = (state_reg != ST_IDLE) || clearing;
    assign accept     = start && !busy;
    assign in_page    = vaddr[OFFSET_WIDTH +: PAGE_W];
    assign cur_page   = addr_reg[OFFSET_WIDTH +: PAGE_W];
    assign cur_offset = addr_reg[OFFSET_WIDTH-1:0];

    tlbsc_tlb u_tlb
    (
        .clk   (clk),
        .rst_n (rst_n),
        .page  (cur_page),
        .frame (frame_reg),
        .cmd   (tcmd),
        .stat  (tstat)
    );

    // table read issued with the accepted word, data ready in the lookup cycle
    tlbsc_ptab u_ptab
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_page  (in_page),
        .rd_word  (pt_rd),
        .wr_en    (pt_wr_en),
        .wr_page  (cur_page),
        .wr_word  (pt_wr),
        .clearing (clearing)
    );

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        frame_next = frame_reg;
        fault_next = fault_reg;
        nff_next   = nff_reg;
        pa_next    = pa_reg;
        hit_next   = hit_reg;
        pf_next    = pf_reg;
        done_next  = 1'b0;
        tcmd       = '0;
        pt_wr_en   = 1'b0;
        pt_wr.valid = 1'b1;
        pt_wr.frame = nff_reg[FRAME_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = vaddr;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                tcmd.touch = 1'b1;
                if (tstat.hit)
                begin
                    pa_next    = {tstat.frame, cur_offset};
                    hit_next   = 1'b1;
                    pf_next    = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (pt_rd.valid)
                    begin
                        frame_next = pt_rd.frame;
                        fault_next = 1'b0;
                    end
                    else
                    begin
                        // page fault: hand out the next free frame
                        frame_next = nff_reg[FRAME_W-1:0];
                        fault_next = 1'b1;
                        pt_wr_en   = 1'b1;
                        if (nff_reg < NFF_W'(PAGE_COUNT))
                        begin
                            nff_next = nff_reg + 1'b1;
                        end
                    end
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                tcmd.step = 1'b1;
                if (!tstat.hand_ref)
                begin
                    pa_next    = {frame_reg, cur_offset};
                    hit_next   = 1'b0;
                    pf_next    = fault_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nff_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nff_reg   <= nff_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        frame_reg <= frame_next;
        fault_reg <= fault_next;
        pa_reg    <= pa_next;
        hit_reg   <= hit_next;
        pf_reg    <= pf_next;
    end

    assign done       = done_reg;
    assign paddr      = pa_reg;
    assign tlb_hit    = hit_reg;
    assign page_fault = pf_reg;

endmodule
